// ===== hdl/mau_pkg.sv =====
// Package: widths, operation codes and shared types of the modular arithmetic unit.
`timescale 1ns / 1ps
package mau_pkg;

  localparam int unsigned ResW = 31;
  localparam int unsigned WideW = 64;
  localparam int unsigned DivW = 64;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam logic [ResW-1:0] ModulusReset = ResW'(1000000007);

  typedef logic [ResW-1:0] res_t;

  typedef enum logic [2:0] {
    OP_REDUCE = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_POW    = 3'd5,
    OP_INC    = 3'd6,
    OP_DEC    = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RA_DIV,
    ST_RB_DIV,
    ST_DISPATCH,
    ST_RAW_DIV,
    ST_RAW_FIX,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_INV_CHECK,
    ST_INV_Q_DIV,
    ST_INV_R_DIV,
    ST_INV_MUL,
    ST_INV_DONE,
    ST_POW_CHECK,
    ST_POW_MRES,
    ST_POW_MSQ,
    ST_DONE
  } state_e;

  // Handshake between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== hdl/mau_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mau_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mau_pkg::unit_req_t        req_i,
  input  logic [mau_pkg::DivW-1:0]  dividend_i,
  input  logic [mau_pkg::ResW-1:0]  divisor_i,
  output mau_pkg::unit_sts_t        sts_o,
  output logic [mau_pkg::DivW-1:0]  quot_o,
  output logic [mau_pkg::ResW-1:0]  rem_o
);
  import mau_pkg::*;

  logic [DivW-1:0]    quot_q, quot_d;
  logic [ResW:0]      rem_q, rem_d;
  logic [ResW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [ResW+1:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DivCntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[DivW-1]} - {2'b00, dvs_q};
      if (!trial[ResW+1]) begin
        rem_d = trial[ResW:0];
      end else begin
        rem_d = {rem_q[ResW-1:0], quot_q[DivW-1]};
      end
      quot_d = {quot_q[DivW-2:0], ~trial[ResW+1]};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = quot_q;
  assign rem_o      = rem_q[ResW-1:0];

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_no_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("divider busy and done together");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < {1'b0, dvs_q}) || (dvs_q == '0))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hdl/mau_mulmod.sv =====
// Bit-serial modular multiplier, shift-and-add with per-bit reduction.
`timescale 1ns / 1ps
module mau_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mau_pkg::unit_req_t       req_i,
  input  logic [mau_pkg::ResW-1:0] a_i,
  input  logic [mau_pkg::ResW-1:0] b_i,
  input  logic [mau_pkg::ResW-1:0] mod_i,
  output mau_pkg::unit_sts_t       sts_o,
  output logic [mau_pkg::ResW-1:0] prod_o
);
  import mau_pkg::*;

  localparam int unsigned CntW = $clog2(ResW + 1);

  logic [ResW-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d, m_q, m_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [ResW+1:0] dbl, dbl_r, add, add_r;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dbl    = {1'b0, acc_q, 1'b0};
    dbl_r  = (dbl >= {2'b00, m_q}) ? dbl - {2'b00, m_q} : dbl;
    add    = dbl_r + {2'b00, a_q};
    add_r  = (add >= {2'b00, m_q}) ? add - {2'b00, m_q} : add;
    if (req_i.start) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      m_d    = mod_i;
      cnt_d  = CntW'(ResW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = b_q[ResW-1] ? add_r[ResW-1:0] : dbl_r[ResW-1:0];
      b_d   = {b_q[ResW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

`ifndef SYNTHESIS
  a_mul_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("multiplier done without busy");
  a_mul_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && a_q < m_q) |-> acc_q < m_q) else $error("multiplier accumulator out of range");
  a_mul_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("multiplier busy and done together");
`endif

endmodule

// ===== hdl/modular_arithmetic_unit.sv =====
// Top level: sequencer for residue operations over a configurable modulus.
// Sequence: both operands are first reduced by the divider; add, sub, inc and dec then finish in dispatch;
// reduce divides the raw value, mul runs the multiplier, div runs the inverse chain and then a multiply,
// pow multiplies and squares once per exponent bit (up to 64), after the inverse chain when negative.
// Throughput: one request at a time; the next transfer is taken once the sequencer is idle.
// Reset: asynchronous, active low; modulus returns to 1000000007, no request in flight.
`timescale 1ns / 1ps
module modular_arithmetic_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mau_pkg::ResW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                req_type_i,
  input  logic [mau_pkg::ResW-1:0]  operand_a_i,
  input  logic [mau_pkg::ResW-1:0]  operand_b_i,
  input  logic signed [mau_pkg::WideW-1:0] exponent_i,
  input  logic signed [mau_pkg::WideW-1:0] raw_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mau_pkg::ResW-1:0]  result_o
);
  import mau_pkg::*;

  state_e state_q, state_d;

  res_t            mod_q;
  op_e             op_q;
  res_t            a_q, a_d, b_q, b_d, r_q, r_d, v_q, v_d, c_q, c_d, p_q, p_d;
  logic [WideW-1:0] e_q, e_d, raw_q;
  logic            neg_q, neg_d, inv_pow_q, inv_pow_d, rawneg_q;
  res_t            out_q;
  logic            out_v_q;

  unit_req_t        div_req, mul_req;
  unit_sts_t        div_sts, mul_sts;
  logic [DivW-1:0]  div_dvd, div_quot;
  res_t             div_rem, mul_a, mul_b, mul_p;
  logic             dvs_c;
  res_t             dvs_mux;

  logic in_xfer, res_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  mau_divider u_div (
    .clk_i, .rst_ni, .req_i(div_req), .dividend_i(div_dvd), .divisor_i(dvs_mux),
    .sts_o(div_sts), .quot_o(div_quot), .rem_o(div_rem)
  );

  mau_mulmod u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .a_i(mul_a), .b_i(mul_b), .mod_i(mod_q),
    .sts_o(mul_sts), .prod_o(mul_p)
  );

  // divisor is the modulus, except in the inverse chain where m is divided by c

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_xfer) state_d = ST_RA_DIV;
      ST_RA_DIV:    if (div_sts.done) state_d = ST_RB_DIV;
      ST_RB_DIV:    if (div_sts.done) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (mod_q < res_t'(2)) state_d = ST_DONE;
        else begin
          unique case (op_q)
            OP_REDUCE: state_d = ST_RAW_DIV;
            OP_MUL:    state_d = ST_MUL_START;
            OP_DIV:    state_d = ST_INV_CHECK;
            OP_POW:    state_d = neg_q ? ST_INV_CHECK : ST_POW_CHECK;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_RAW_DIV:   if (div_sts.done) state_d = ST_RAW_FIX;
      ST_RAW_FIX:   state_d = ST_DONE;
      ST_MUL_START: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (mul_sts.done) state_d = ST_DONE;
      ST_INV_CHECK: state_d = (c_q > res_t'(1)) ? ST_INV_Q_DIV : ST_INV_DONE;
      ST_INV_Q_DIV: if (div_sts.done) state_d = ST_INV_R_DIV;
      ST_INV_R_DIV: if (mul_sts.done) state_d = ST_INV_CHECK;
      ST_INV_MUL:   if (mul_sts.done) state_d = ST_DONE;
      ST_INV_DONE:  state_d = inv_pow_q ? ST_POW_CHECK : ST_INV_MUL;
      ST_POW_CHECK: state_d = (e_q == '0) ? ST_DONE : ST_POW_MRES;
      ST_POW_MRES:  if (mul_sts.done) state_d = ST_POW_MSQ;
      ST_POW_MSQ:   if (mul_sts.done) state_d = ST_POW_CHECK;
      ST_DONE:      if (!out_v_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // unit starts and operands
  logic       start_div, start_mul;
  logic [DivW-1:0] dvd_sel;
  res_t       mb_sel, ma_sel;

  always_comb begin
    start_div = 1'b0;
    start_mul = 1'b0;
    dvd_sel   = '0;
    ma_sel    = r_q;
    mb_sel    = v_q;
    dvs_c     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        start_div = in_xfer;
        dvd_sel   = {{(DivW-ResW){1'b0}}, operand_a_i};
      end
      ST_RA_DIV: begin
        start_div = div_sts.done;
        dvd_sel   = {{(DivW-ResW){1'b0}}, b_q};
      end
      ST_DISPATCH: begin
        start_div = (op_q == OP_REDUCE) && (mod_q >= res_t'(2));
        dvd_sel   = rawneg_q ? (~raw_q + 1'b1) : raw_q;
      end
      ST_MUL_START: begin
        start_mul = 1'b1;
        ma_sel = a_q;
        mb_sel = b_q;
      end
      ST_INV_CHECK: begin
        start_div = c_q > res_t'(1);
        dvd_sel   = {{(DivW-ResW){1'b0}}, mod_q};
        dvs_c     = 1'b1;
      end
      ST_INV_Q_DIV: begin
        dvs_c     = 1'b1;
        start_mul = div_sts.done;
        ma_sel    = p_q;
        mb_sel    = (div_rem == '0) ? res_t'(0) : mod_q - div_quot[ResW-1:0];
      end
      ST_INV_DONE: begin
        start_mul = !inv_pow_q;
        ma_sel    = a_q;
        mb_sel    = (c_q == res_t'(1)) ? p_q : res_t'(0);
      end
      ST_POW_CHECK: begin
        start_mul = e_q != '0;
        ma_sel    = r_q;
        mb_sel    = e_q[0] ? v_q : res_t'(1);
      end
      ST_POW_MRES: begin
        start_mul = mul_sts.done;
        ma_sel    = v_q;
        mb_sel    = v_q;
      end
      default: ;
    endcase
  end

  assign dvs_mux       = dvs_c ? c_q : mod_q;
  assign div_req.start = start_div;
  assign mul_req.start = start_mul;
  assign div_dvd       = dvd_sel;
  assign mul_a         = ma_sel;
  assign mul_b         = mb_sel;

  // datapath registers
  always_comb begin
    a_d = a_q; b_d = b_q; r_d = r_q; v_d = v_q; c_d = c_q; p_d = p_q;
    e_d = e_q; neg_d = neg_q; inv_pow_d = inv_pow_q;
    res_done = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_xfer) begin
        b_d = operand_b_i;
        e_d = exponent_i[WideW-1] ? (~exponent_i + 1'b1) : exponent_i;
        neg_d = exponent_i[WideW-1];
      end
      ST_RA_DIV: if (div_sts.done) a_d = div_rem;
      ST_RB_DIV: if (div_sts.done) b_d = div_rem;
      ST_DISPATCH: begin
        p_d = res_t'(1);
        r_d = res_t'(1);
        v_d = a_q;
        inv_pow_d = (op_q == OP_POW);
        c_d = (op_q == OP_POW) ? a_q : b_q;
        unique case (op_q)
          OP_ADD: r_d = ({1'b0, a_q} + {1'b0, b_q} >= {1'b0, mod_q}) ?
                        a_q + b_q - mod_q : a_q + b_q;
          OP_SUB: r_d = (a_q >= b_q) ? a_q - b_q : a_q + mod_q - b_q;
          OP_INC: r_d = (a_q == mod_q - 1'b1) ? res_t'(0) : a_q + 1'b1;
          OP_DEC: r_d = (a_q == '0) ? mod_q - 1'b1 : a_q - 1'b1;
          default: ;
        endcase
        if (mod_q < res_t'(2)) r_d = '0;
      end
      ST_RAW_FIX: r_d = (rawneg_q && div_rem != '0) ? mod_q - div_rem : div_rem;
      ST_MUL_WAIT: if (mul_sts.done) r_d = mul_p;
      ST_INV_Q_DIV: if (div_sts.done) c_d = div_rem;
      ST_INV_R_DIV: if (mul_sts.done) p_d = mul_p;
      ST_INV_DONE: if (inv_pow_q) v_d = (c_q == res_t'(1)) ? p_q : res_t'(0);
      ST_INV_MUL: if (mul_sts.done) r_d = mul_p;
      ST_POW_MRES: if (mul_sts.done) r_d = mul_p;
      ST_POW_MSQ: if (mul_sts.done) begin
        v_d = mul_p;
        e_d = {1'b0, e_q[WideW-1:1]};
      end
      ST_DONE: res_done = !out_v_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mod_q   <= ModulusReset;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
      if (res_done) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; r_q <= r_d; v_q <= v_d; c_q <= c_d; p_q <= p_d;
    e_q <= e_d; neg_q <= neg_d; inv_pow_q <= inv_pow_d;
    if (in_xfer) begin
      op_q     <= op_e'(req_type_i);
      raw_q    <= raw_value_i;
      rawneg_q <= raw_value_i[WideW-1];
    end
    if (res_done) out_q <= r_q;
  end

  assign out_valid_o = out_v_q;
  assign result_o    = out_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> out_v_q && $stable(out_q))
    else $error("result dropped or changed while waiting");
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_sts.busy && !mul_sts.busy) else $error("unit busy in idle");
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> (out_q < mod_q) || (mod_q < res_t'(2)))
    else $error("result not reduced");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for the modular arithmetic unit: directed and random requests checked against a behavioral predictor.
`timescale 1ns / 1ps
module tb;
  import mau_pkg::*;

  typedef struct {
    op_e             op;
    res_t            a;
    res_t            b;
    logic [63:0]     expo;
    logic [63:0]     raw;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  res_t        cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  res_t        operand_a_i = '0;
  res_t        operand_b_i = '0;
  logic signed [63:0] exponent_i = '0;
  logic signed [63:0] raw_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  res_t        result_o;

  modular_arithmetic_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .req_type_i, .operand_a_i, .operand_b_i, .exponent_i, .raw_value_i,
    .out_valid_o, .out_ready_i, .result_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  req_t        pending_reqs[$];
  res_t        expected_residues[$];
  logic [63:0] modulus_q = 64'd1000000007;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          timed_out = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  localparam int WatchdogLimit = 200000;

  function automatic logic [63:0] inv_mod(logic [63:0] x, logic [63:0] m);
    logic [63:0] c, prod;
    c = x;
    prod = 1;
    while (c > 1) begin
      prod = (prod * ((m - m / c) % m)) % m;
      c = m % c;
    end
    return (c == 1) ? prod : 64'd0;
  endfunction

  function automatic res_t predict_residue(req_t r, logic [63:0] m);
    logic [63:0] a, b, res, v, n, t;
    if (m < 2) return '0;
    a = r.a % m;
    b = r.b % m;
    case (r.op)
      OP_REDUCE: begin
        if (r.raw[63]) begin
          t = (64'd0 - r.raw) % m;
          res = (t != 0) ? m - t : 64'd0;
        end else begin
          res = r.raw % m;
        end
      end
      OP_ADD: res = (a + b) % m;
      OP_SUB: res = (a >= b) ? a - b : a + m - b;
      OP_MUL: res = (a * b) % m;
      OP_DIV: res = (a * inv_mod(b, m)) % m;
      OP_POW: begin
        res = 1 % m;
        v = a;
        n = r.expo[63] ? 64'd0 - r.expo : r.expo;
        if (r.expo[63]) v = inv_mod(v, m);
        while (n > 0) begin
          if (n[0]) res = (res * v) % m;
          v = (v * v) % m;
          n = n >> 1;
        end
      end
      OP_INC: res = (a == m - 1) ? 64'd0 : a + 1;
      default: res = (a == 0) ? m - 1 : a - 1;
    endcase
    return res_t'(res);
  endfunction

  // Driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 16);
      end else if (!in_valid_i) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_type_i <= r.op;
          operand_a_i <= r.a;
          operand_b_i <= r.b;
          exponent_i <= r.expo;
          raw_value_i <= r.raw;
          in_valid_i <= 1'b1;
        end
      end
      if (out_taken) begin
        out_ready_i <= 1'b0;
        recv_gap <= $urandom_range(0, 16);
      end else if (!out_ready_i) begin
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
        else out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    in_taken  <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        req_t r;
        r.op = op_e'(req_type_i);
        r.a = operand_a_i;
        r.b = operand_b_i;
        r.expo = exponent_i;
        r.raw = raw_value_i;
        expected_residues.push_back(predict_residue(r, modulus_q));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_residues.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", result_o);
        end else begin
          res_t e;
          e = expected_residues.pop_front();
          if (e !== result_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %0d got %0d", e, result_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) timed_out = 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic res_t rand_res();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return res_t'($urandom_range(0, 20));
      default: return res_t'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] rand_expo();
    case ($urandom_range(0, 5))
      0: return 64'(signed'($urandom_range(0, 40)) - 20);
      1: return {1'b1, 63'd0};
      2: return {1'b0, {63{1'b1}}};
      default: return rand64();
    endcase
  endfunction

  task automatic queue_req(op_e op, res_t a, res_t b, logic [63:0] expo, logic [63:0] raw);
    req_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.expo = expo;
    r.raw = raw;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      queue_req(op_e'($urandom_range(0, 7)), rand_res(), rand_res(), rand_expo(), rand64());
  endtask

  task automatic drain();
    while ((pending_reqs.size() > 0 || in_valid_i || expected_residues.size() > 0)
           && !timed_out)
      @(posedge clk_i);
  endtask

  task automatic write_modulus(res_t value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_q = 64'(value);
  endtask

  initial begin
    res_t moduli[7];
    moduli = '{31'd7, 31'd2147483647, 31'd2, 31'd1, 31'd0, 31'd1000, 31'd65521};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases at reset modulus
    queue_req(OP_REDUCE, '0, '0, '0, {1'b1, 63'd0});
    queue_req(OP_REDUCE, '0, '0, '0, {1'b0, {63{1'b1}}});
    queue_req(OP_REDUCE, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(OP_ADD, res_t'(1000000006), res_t'(1000000006), '0, '0);
    queue_req(OP_SUB, '0, '1, '0, '0);
    queue_req(OP_MUL, '1, '1, '0, '0);
    queue_req(OP_DIV, res_t'(12345), '0, '0, '0);
    queue_req(OP_DIV, res_t'(12345), res_t'(678), '0, '0);
    queue_req(OP_POW, res_t'(3), '0, '0, '0);
    queue_req(OP_POW, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    queue_req(OP_POW, res_t'(5), '0, {1'b1, 63'd0}, '0);
    queue_req(OP_POW, res_t'(5), '0, {1'b0, {63{1'b1}}}, '0);
    queue_req(OP_INC, res_t'(1000000006), '0, '0, '0);
    queue_req(OP_INC, '1, '0, '0, '0);
    queue_req(OP_DEC, '0, '0, '0, '0);
    queue_req(OP_DEC, '1, '1, '1, '1);
    drain();

    // random requests at reset modulus, then wait until every result has returned
    queue_random(30);
    drain();

    foreach (moduli[i]) begin
      repeat (20000) @(posedge clk_i);
      write_modulus(moduli[i]);
      queue_random(12);
      drain();
    end
    repeat (20000) @(posedge clk_i);
    write_modulus(31'd1000000007);
    queue_random(15);
    drain();
    repeat (100) @(posedge clk_i);

    if (timed_out) begin
      $display("Testbench completed WITH ERRORS");
    end else if (mismatches == 0 && expected_residues.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/mau_pkg.sv
hdl/mau_divider.sv
hdl/mau_mulmod.sv
hdl/modular_arithmetic_unit.sv
sim/tb.sv
